[rtl/dq_pkg.sv]
// shared constants and control types for the double-ended queue
package dq_pkg;

  localparam int DQ_DEPTH      = 64;
  localparam int DQ_DATA_WIDTH = 32;

  localparam int OP_W = 3;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take;   // input beat accepted, apply the operation
    logic rd;     // read front and back slots
    logic load;   // capture result into the output register
  } dq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // output register holds a beat that is not taken this cycle
  } dq_sts_t;

endpackage

[rtl/dq_ram.sv]
// generic single-write, dual-read memory with registered read data
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/dq_ctrl.sv]
// sequencer for one queue operation: apply, read, load result
module dq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  dq_pkg::dq_sts_t sts,
  output dq_pkg::dq_cmd_t cmd
);

  import dq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // wait here while the previous result is still held
        if (!sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/dq_dpath.sv]
// queue indices, entry count, slot memory and output register
module dq_dpath #(
  parameter int DEPTH      = dq_pkg::DQ_DEPTH,
  parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dq_pkg::dq_cmd_t               cmd,
  output dq_pkg::dq_sts_t               sts,
  input  logic [dq_pkg::OP_W-1:0]       in_op,
  input  logic [DATA_WIDTH-1:0]         in_data,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [DATA_WIDTH-1:0]         out_front,
  output logic [DATA_WIDTH-1:0]         out_back,
  output logic [$clog2(DEPTH+1)-1:0]    out_count,
  output logic                          out_empty,
  output logic                          out_full,
  output logic [dq_pkg::ST_W-1:0]       out_status
);

  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    idx_next = (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    idx_prev = (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [ST_W-1:0] status_r, status_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [DATA_WIDTH-1:0] front_r, back_r;
  logic [CW-1:0]         ocount_r;
  logic                  oempty_r, ofull_r;
  logic [ST_W-1:0]       ostatus_r;

  logic                  full, empty;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] rd_front, rd_back;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = tail_r;
    if (cmd.take) begin
      status_nxt = ST_OK;
      case (in_op)
        OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            we        = 1'b1;
            waddr     = tail_r;
            tail_nxt  = idx_next(tail_r);
            count_nxt = count_r + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            we        = 1'b1;
            waddr     = idx_prev(head_r);
            head_nxt  = idx_prev(head_r);
            count_nxt = count_r + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            head_nxt  = idx_next(head_r);
            count_nxt = count_r - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            tail_nxt  = idx_prev(tail_r);
            count_nxt = count_r - CW'(1);
          end
        end
        OP_CLEAR: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // write lands at the take edge, the read of the new front and back follows in the next cycle
  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (in_data),
    .re      (cmd.rd),
    .raddr_a (head_r),
    .raddr_b (idx_prev(tail_r)),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  assign sts.out_busy = out_valid_r && !out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      front_r   <= empty ? '0 : rd_front;
      back_r    <= empty ? '0 : rd_back;
      ocount_r  <= count_r;
      oempty_r  <= empty;
      ofull_r   <= full;
      ostatus_r <= status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_front  = front_r;
  assign out_back   = back_r;
  assign out_count  = ocount_r;
  assign out_empty  = oempty_r;
  assign out_full   = ofull_r;
  assign out_status = ostatus_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(head_r) + SW'(count_r) == SW'(tail_r)) ||
    (SW'(head_r) + SW'(count_r) == SW'(tail_r) + SW'(DEPTH)))
    else $error("head, count and tail disagree");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take && !full && (in_op == OP_PUSH_BACK || in_op == OP_PUSH_FRONT)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted push did not add an entry");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    status_r == ST_OVERFLOW |-> count_r == FULL_CNT)
    else $error("overflow reported on a queue that is not full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    status_r == ST_UNDERFLOW |-> count_r == '0)
    else $error("underflow reported on a queue that is not empty");
`endif

endmodule

[rtl/double_ended_queue_core.sv]
// top level of the bounded double-ended queue
//
// input channel (in_*): one beat per operation; in_tuser carries the op code
// (push back, push front, pop front, pop back, clear), in_tdata the value
// to push, ignored by pops and clear. unused op codes only report ok.
// result channel (out_*): exactly one beat per accepted operation, in order,
// with the front and back values (zero when empty), the entry count,
// empty and full flags and a status (ok, overflow, underflow).
// sequence: the input beat writes the slot memory and moves the indices,
// the next step reads front and back through the memory's registered read
// ports, and the last loads the output register, which raises out_tvalid.
// a new beat is taken only once the previous operation has loaded its
// result; in_tready is low during the read and load steps.
// a stalled receiver holds the result in the output register; the next
// operation is still accepted and carried up to the load step, where it
// waits until the held beat is taken.
// reset: indices and count go to zero and no beat is pending; slot contents
// are not cleared, so no clearing pass is needed
module double_ended_queue_core #(
  parameter int DEPTH      = dq_pkg::DQ_DEPTH,
  parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // data_in
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]             in_tdata,
  // op
  input  logic [dq_pkg::OP_W-1:0]                     in_tuser,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // front_value, back_value, entry_count, is_empty, is_full, status
  output logic [((2*DATA_WIDTH+$clog2(DEPTH+1)+4+7)/8)*8-1:0] out_tdata
);

  import dq_pkg::*;

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int OUT_W  = 2 * DATA_WIDTH + CW + 2 + ST_W;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  dq_cmd_t cmd;
  dq_sts_t sts;

  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;
  logic [CW-1:0]         entry_count;
  logic                  is_empty;
  logic                  is_full;
  logic [ST_W-1:0]       status;

  // operation sequencer
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // indices, slot memory and result register
  dq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_data    (in_tdata[DATA_WIDTH-1:0]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_front  (front_value),
    .out_back   (back_value),
    .out_count  (entry_count),
    .out_empty  (is_empty),
    .out_full   (is_full),
    .out_status (status)
  );

  // pack result fields from the lowest bit up, zero fill to whole bytes
  assign out_tdata = OUT_TW'({status, is_full, is_empty, entry_count,
                              back_value, front_value});

endmodule
